### sv/contiguous_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous page allocator
// Each macro clocks on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Widths, codes and reset values shared by the page allocator files.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int SIZE_W    = 20;
  localparam int ADDR_W    = 32;
  localparam int PM_W      = 10;
  localparam int KB_W      = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_OOM       = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_MANAGED = 2'd1;

  localparam logic [ADDR_W-1:0] BASE_RESET  = 32'h1000_C000;
  localparam logic [PM_W-1:0]   PAGES_RESET = 10'd512;

endpackage

### sv/cpa_size_div.sv
// ----------------------------------------------------------------------------
// cpa_size_div
// Page count of a byte size, registered in the cycle after start.
// ----------------------------------------------------------------------------
module cpa_size_div
  import cpa_pkg::*;
#(
  parameter int DIVISOR = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SIZE_W-1:0] dividend,
  output logic              done,
  output logic [SIZE_W-1:0] quotient
);

  // The page size is a power of two, so the page count is a plain shift.
  localparam int SHIFT = $clog2(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        quotient <= dividend >> SHIFT;
      end
    end
  end

endmodule

### sv/contiguous_page_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of contiguous page runs over a single page table memory.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                    Handshake
//   --------  -----------------------------------------  ------------------------
//   request   req_type, size_bytes, block_address        start high, busy low
//   result    status, address, free_kb                   result_valid, one cycle
//   config    cfg_index, cfg_data                        cfg_valid and cfg_ready
//
// After reset a clearing pass writes every entry of the page table, with busy high.
// Register writes are taken only while idle with start low. One item at a time:
// a pending register write first forces a recount of the free pages below the
// limit. A nonzero allocate passes through dispatch and page count, a first-fit
// scan and a write of each page taken; a free makes a search for the block and
// a release of its run. The result is loaded in S_FINISH and shown the cycle after.
//
module contiguous_page_allocator
  import cpa_pkg::*;
#(
  parameter int PAGES      = 512,
  parameter int PAGE_BYTES = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [SIZE_W-1:0]    size_bytes,
  input  logic [ADDR_W-1:0]    block_address,
  output logic                 result_valid,
  output logic [1:0]           status,
  output logic [ADDR_W-1:0]    address,
  output logic [KB_W-1:0]      free_kb,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  // Index width of the table, and width of counts that may reach PAGES itself.
  localparam int AW = $clog2(PAGES);
  localparam int RW = $clog2(PAGES + 1);
  localparam int CW = (RW > PM_W) ? RW : PM_W;
  localparam int MW = (RW + 17 > 21) ? RW + 17 : 21;

  localparam logic [RW-1:0]     PAGES_R = RW'(PAGES);
  localparam logic [CW-1:0]     PAGES_C = CW'(PAGES);
  localparam logic [ADDR_W-1:0] PB32    = ADDR_W'(PAGE_BYTES);

  // Each table entry holds the used mark and the pages left in its run.
  typedef struct packed {
    logic          used;
    logic [RW-1:0] run;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RECOUNT,
    S_DISPATCH,
    S_DIV,
    S_ALLOC_SCAN,
    S_ALLOC_WRITE,
    S_FIND,
    S_RELEASE,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [ADDR_W-1:0] base_address;
  logic [PM_W-1:0]   pages_managed;
  logic              dirty;

  // Latched request.
  logic              req_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] baddr_q;

  // Table sweep: iss is the next entry read, pidx the entry whose data is back.
  logic [RW-1:0]     iss;
  logic              pvalid;
  logic [RW-1:0]     pidx;

  logic [RW-1:0]     cnt;
  logic [RW-1:0]     free_pages;
  logic [RW-1:0]     run_len;
  logic [RW-1:0]     rem;
  logic [SIZE_W-1:0] need_q;
  logic [AW-1:0]     wptr;
  logic [AW-1:0]     start_page;
  logic [ADDR_W-1:0] paddr;
  status_t           status_q;
  logic [ADDR_W-1:0] addr_q;

  // The page table and its single port pair.
  entry_t        mem [PAGES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        rd_data;

  logic              div_start;
  logic              div_done;
  logic [SIZE_W-1:0] div_q;

  logic [CW-1:0] pm_ext;
  logic [RW-1:0] lim;
  logic [RW-1:0] run_new;
  logic [RW-1:0] start_calc;
  logic [RW-1:0] rel_len;
  logic [RW-1:0] avail;
  logic [MW-1:0] kb_prod;

  assign busy = (state != S_IDLE);

  // Registers change only between items, never while one is being worked on
  // or taken in the same cycle.
  assign cfg_ready = !busy && !start;

  // Only pages below min(pages_managed, PAGES) can be handed out.
  assign pm_ext = CW'(pages_managed);
  assign lim    = (pm_ext > PAGES_C) ? PAGES_C[RW-1:0] : pm_ext[RW-1:0];

  // First-fit bookkeeping on the entry that has just come back from the table.
  assign run_new    = rd_data.used ? '0 : run_len + RW'(1);
  assign start_calc = pidx + RW'(1) - run_new;

  // A used page with no run length still releases itself; never past the end.
  assign rel_len = (rd_data.run == '0) ? RW'(1) : rd_data.run;
  assign avail   = PAGES_R - pidx;

  assign kb_prod = MW'(free_pages) * MW'(PAGE_BYTES);

  assign div_start = (state == S_DISPATCH) && (req_q == REQ_ALLOC) && (size_q != '0);

  cpa_size_div #(
    .DIVISOR (PAGE_BYTES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (size_q),
    .done     (div_done),
    .quotient (div_q)
  );

  // Reads run ahead of writes on rising addresses, so a write never meets a
  // read of the same entry in the same cycle and no forwarding is needed.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = iss[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = pidx[AW-1:0];
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = iss[AW-1:0];
      end
      S_RECOUNT, S_ALLOC_SCAN: begin
        mem_re = (iss != lim);
      end
      S_FIND: begin
        mem_re = (iss != PAGES_R);
      end
      S_ALLOC_WRITE: begin
        mem_we         = 1'b1;
        mem_waddr      = wptr;
        mem_wdata.used = 1'b1;
        mem_wdata.run  = rem;
      end
      S_RELEASE: begin
        mem_re = (rem != '0);
        mem_we = pvalid;
      end
      S_IDLE, S_DISPATCH, S_DIV, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      iss           <= '0;
      pvalid        <= 1'b0;
      dirty         <= 1'b1;
      result_valid  <= 1'b0;
      base_address  <= BASE_RESET;
      pages_managed <= PAGES_RESET;
    end else begin
      result_valid <= 1'b0;

      // Common sweep bookkeeping; the states below override it where needed.
      if (mem_re) begin
        iss <= iss + RW'(1);
      end
      pvalid <= mem_re;
      pidx   <= iss;

      unique case (state)
        S_CLEAR: begin
          iss <= iss + RW'(1);
          if (iss == PAGES_R - RW'(1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            req_q   <= req_type;
            size_q  <= size_bytes;
            baddr_q <= block_address;
            iss     <= '0;
            cnt     <= '0;
            state   <= dirty ? S_RECOUNT : S_DISPATCH;
          end
        end

        // Pending register writes or a fresh reset: count the free pages below the limit.
        S_RECOUNT: begin
          if (pvalid && !rd_data.used) begin
            cnt <= cnt + RW'(1);
          end
          if ((iss == lim) && !pvalid) begin
            free_pages <= cnt;
            dirty      <= 1'b0;
            state      <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          iss   <= '0;
          paddr <= base_address;
          if (req_q == REQ_FREE) begin
            state <= S_FIND;
          end else if (size_q == '0) begin
            status_q <= ST_ZERO;
            addr_q   <= '0;
            state    <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            need_q  <= (div_q == '0) ? SIZE_W'(1) : div_q;
            run_len <= '0;
            iss     <= '0;
            state   <= S_ALLOC_SCAN;
          end
        end

        S_ALLOC_SCAN: begin
          if (pvalid) begin
            run_len <= run_new;
          end
          if (pvalid && (SIZE_W'(run_new) == need_q)) begin
            start_page <= start_calc[AW-1:0];
            wptr       <= start_calc[AW-1:0];
            rem        <= run_new;
            state      <= S_ALLOC_WRITE;
          end else if ((iss == lim) && !pvalid) begin
            status_q <= ST_OOM;
            addr_q   <= '0;
            state    <= S_FINISH;
          end
        end

        // Mark the run used; each entry holds the pages left from it onward.
        S_ALLOC_WRITE: begin
          wptr <= wptr + AW'(1);
          rem  <= rem - RW'(1);
          if (rem == RW'(1)) begin
            free_pages <= free_pages - need_q[RW-1:0];
            status_q   <= ST_OK;
            addr_q     <= base_address + ADDR_W'(start_page) * PB32;
            state      <= S_FINISH;
          end
        end

        // Lowest used page whose address matches; paddr tracks pidx.
        S_FIND: begin
          if (pvalid) begin
            paddr <= paddr + PB32;
          end
          if (pvalid && rd_data.used && (paddr == baddr_q)) begin
            rem    <= (rel_len > avail) ? avail : rel_len;
            iss    <= pidx;
            pvalid <= 1'b0;
            state  <= S_RELEASE;
          end else if ((iss == PAGES_R) && !pvalid) begin
            status_q <= ST_NOT_FOUND;
            addr_q   <= '0;
            state    <= S_FINISH;
          end
        end

        // Read each page of the run, clear it, and credit it if it was used
        // and lies below the limit.
        S_RELEASE: begin
          if (mem_re) begin
            rem <= rem - RW'(1);
          end
          if (pvalid && rd_data.used && (pidx < lim)) begin
            free_pages <= free_pages + RW'(1);
          end
          if ((rem == '0) && !pvalid) begin
            status_q <= ST_OK;
            addr_q   <= '0;
            state    <= S_FINISH;
          end
        end

        S_FINISH: begin
          result_valid <= 1'b1;
          status       <= status_q;
          address      <= addr_q;
          free_kb      <= kb_prod[KB_W+9:10];
          state        <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BASE_ADDRESS: begin
            base_address <= cfg_data;
            dirty        <= 1'b1;
          end
          CFG_PAGES_MANAGED: begin
            pages_managed <= cfg_data[PM_W-1:0];
            dirty         <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### sv/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_checker
// Port-level checks on the request and result sides of the page allocator.
// ----------------------------------------------------------------------------
`include "contiguous_page_allocator_macros.svh"

module cpa_checker
  import cpa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input logic [1:0]        status,
  input logic [ADDR_W-1:0] address
);

  // An accepted item always occupies the block in the following cycle.
  `CPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

  // A result strobe lasts exactly one cycle.
  `CPA_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe held")

  // The block is free again when its result appears.
  `CPA_ASSERT_SAME(a_result_idle, result_valid, !busy, "busy while result shown")

  // Every failed request reports a zero address.
  `CPA_ASSERT_SAME(a_fail_zero_addr, result_valid && (status != ST_OK), address == '0,
                   "failed request with non-zero address")

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .status       (status),
  .address      (address)
);
